/* rtl/nps_pkg.sv */
// Shared constants and controller/datapath interface types for the priority scheduler.
package nps_pkg;

    localparam int MAX_JOBS = 16;
    localparam int IDX_W    = $clog2(MAX_JOBS);
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    localparam int TIME_W   = 23;
    localparam int ARR_W    = 16;
    localparam int DUR_W    = 16;
    localparam int PRI_W    = 8;
    localparam int JOBID_W  = 5;

    localparam logic [1:0] ST_PENDING = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_DONE    = 2'd2;

    typedef struct packed {
        logic load;       // store an incoming job
        logic begin_run;  // zero time and completion count
        logic scan_init;  // start a sweep at the highest stored id
        logic scan_step;  // examine one job
        logic commit;     // dispatch the best job or jump time
        logic finish;     // return the batch to its reset state
    } nps_cmd_t;

    typedef struct packed {
        logic scan_last;  // current sweep index is zero
        logic best_valid; // a ready job was found in the sweep
        logic min_valid;  // a pending job is still to arrive
        logic eor;        // registered result is the last of the run
    } nps_status_t;

endpackage

/* rtl/nonpreemptive_priority_scheduler.sv */
// Top level of the non-preemptive priority scheduler.
// Input channel: one job per transaction (arrival, duration, priority_req, last).
// Jobs are numbered 1, 2, 3 in load order; up to MAX_JOBS are kept, the rest are
// dropped and reported through overflowed. Loads are accepted only while idle.
// The transaction with last set closes the batch and starts the schedule.
// Each dispatch sweeps all stored jobs one per cycle through a single read port
// of the job stores; the sweep runs again whenever the clock must jump to the
// next arrival.
// Output channel: one transaction per stored job in completion order; end_of_run
// marks the final one, whose finish_time is the total time.
// in_stall is high from the closing transaction until the final result has
// been taken. While out_stall is high the result is held and no further
// dispatch is made.
// Reset clears the batch: no jobs stored, clock at zero, all jobs pending.
// After the final result the block returns to that state for the next batch.
module nonpreemptive_priority_scheduler
    import nps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ARR_W-1:0]    arrival,
    input  logic [DUR_W-1:0]    duration,
    input  logic [PRI_W-1:0]    priority_req,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [JOBID_W-1:0]  job_id,
    output logic [TIME_W-1:0]   start_time,
    output logic [TIME_W-1:0]   finish_time,
    output logic [TIME_W-1:0]   turnaround,
    output logic [TIME_W-1:0]   waiting,
    output logic [TIME_W-1:0]   response,
    output logic                overflowed,
    output logic                end_of_run
);

    nps_cmd_t    cmd;
    nps_status_t status;

    nps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last      (last),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    nps_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .arrival      (arrival),
        .duration     (duration),
        .priority_req (priority_req),
        .job_id       (job_id),
        .start_time   (start_time),
        .finish_time  (finish_time),
        .turnaround   (turnaround),
        .waiting      (waiting),
        .response     (response),
        .overflowed   (overflowed),
        .end_of_run   (end_of_run)
    );

endmodule

/* rtl/nps_datapath.sv */
// Job stores, sweep logic, simulated clock and result registers.
module nps_datapath
    import nps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  nps_cmd_t            cmd,
    output nps_status_t         status,
    input  logic [ARR_W-1:0]    arrival,
    input  logic [DUR_W-1:0]    duration,
    input  logic [PRI_W-1:0]    priority_req,
    output logic [JOBID_W-1:0]  job_id,
    output logic [TIME_W-1:0]   start_time,
    output logic [TIME_W-1:0]   finish_time,
    output logic [TIME_W-1:0]   turnaround,
    output logic [TIME_W-1:0]   waiting,
    output logic [TIME_W-1:0]   response,
    output logic                overflowed,
    output logic                end_of_run
);

    logic [ARR_W-1:0]  arr_mem   [MAX_JOBS];
    logic [DUR_W-1:0]  dur_mem   [MAX_JOBS];
    logic [PRI_W-1:0]  pri_mem   [MAX_JOBS];
    logic [TIME_W-1:0] stamp_mem [MAX_JOBS];
    logic [1:0]        state_reg [MAX_JOBS];

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  done_reg;
    logic              ovf_reg;
    logic [TIME_W-1:0] time_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic              best_valid_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [PRI_W-1:0]  best_pri_reg;
    logic [TIME_W-1:0] best_stamp_reg;
    logic [ARR_W-1:0]  best_arr_reg;
    logic [DUR_W-1:0]  best_dur_reg;
    logic              min_valid_reg;
    logic [ARR_W-1:0]  min_arr_reg;

    logic [JOBID_W-1:0] id_reg;
    logic [TIME_W-1:0]  start_reg;
    logic [TIME_W-1:0]  fin_reg;
    logic [TIME_W-1:0]  tat_reg;
    logic [TIME_W-1:0]  resp_reg;
    logic               ovf_out_reg;
    logic               eor_reg;

    logic [IDX_W-1:0]  rd_addr;
    logic [ARR_W-1:0]  rd_arr_reg;
    logic [DUR_W-1:0]  rd_dur_reg;
    logic [PRI_W-1:0]  rd_pri_reg;
    logic [TIME_W-1:0] rd_stamp_reg;
    logic [1:0]        rd_state;
    logic              arrived;
    logic              is_ready;
    logic              is_later;
    logic [TIME_W-1:0] eff_stamp;
    logic              better;
    logic [TIME_W-1:0] fin_next;
    logic [TIME_W-1:0] resp_next;

    // Read address follows the next sweep index so read data lines up with idx_reg
    always_comb
    begin
        if (cmd.scan_init)
            rd_addr = IDX_W'(count_reg - CNT_W'(1));
        else if (cmd.scan_step)
            rd_addr = idx_reg - IDX_W'(1);
        else
            rd_addr = idx_reg;
    end

    // Examine the job at the sweep index
    always_comb
    begin
        rd_state  = state_reg[idx_reg];
        arrived   = TIME_W'(rd_arr_reg) <= time_reg;
        is_ready  = (rd_state == ST_READY) || (rd_state == ST_PENDING && arrived);
        is_later  = (rd_state == ST_PENDING) && !arrived;
        eff_stamp = (rd_state == ST_READY) ? rd_stamp_reg : time_reg;
        better    = !best_valid_reg || (rd_pri_reg < best_pri_reg)
                    || (rd_pri_reg == best_pri_reg && eff_stamp < best_stamp_reg);
        fin_next  = time_reg + TIME_W'(best_dur_reg);
        resp_next = time_reg - TIME_W'(best_arr_reg);
    end

    // Job stores written on load, stamps in the sweep; registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.load && count_reg < CNT_W'(MAX_JOBS))
        begin
            arr_mem[count_reg[IDX_W-1:0]] <= arrival;
            dur_mem[count_reg[IDX_W-1:0]] <= duration;
            pri_mem[count_reg[IDX_W-1:0]] <= priority_req;
        end
        if (cmd.scan_step && rd_state == ST_PENDING && arrived)
            stamp_mem[idx_reg] <= time_reg;
        rd_arr_reg   <= arr_mem[rd_addr];
        rd_dur_reg   <= dur_mem[rd_addr];
        rd_pri_reg   <= pri_mem[rd_addr];
        rd_stamp_reg <= stamp_mem[rd_addr];
    end

    // Job state flags, all pending after reset and at batch end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_JOBS; i++)
                state_reg[i] <= ST_PENDING;
        end
        else if (cmd.finish)
        begin
            for (int i = 0; i < MAX_JOBS; i++)
                state_reg[i] <= ST_PENDING;
        end
        else
        begin
            if (cmd.load && count_reg < CNT_W'(MAX_JOBS))
                state_reg[count_reg[IDX_W-1:0]] <= ST_PENDING;
            if (cmd.scan_step && rd_state == ST_PENDING && arrived)
                state_reg[idx_reg] <= ST_READY;
            if (cmd.commit && best_valid_reg)
                state_reg[best_idx_reg] <= ST_DONE;
        end
    end

    // Batch counters, clock and sweep bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            done_reg       <= '0;
            ovf_reg        <= 1'b0;
            time_reg       <= '0;
            idx_reg        <= '0;
            best_valid_reg <= 1'b0;
            min_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (count_reg < CNT_W'(MAX_JOBS))
                    count_reg <= count_reg + CNT_W'(1);
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.begin_run)
            begin
                time_reg <= '0;
                done_reg <= '0;
            end
            if (cmd.scan_init)
            begin
                idx_reg        <= rd_addr;
                best_valid_reg <= 1'b0;
                min_valid_reg  <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                idx_reg <= rd_addr;
                if (is_ready && better)
                    best_valid_reg <= 1'b1;
                if (is_later && (!min_valid_reg || rd_arr_reg < min_arr_reg))
                    min_valid_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                if (best_valid_reg)
                begin
                    time_reg <= fin_next;
                    done_reg <= done_reg + CNT_W'(1);
                end
                else if (min_valid_reg)
                    time_reg <= TIME_W'(min_arr_reg);
            end
            if (cmd.finish)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
                time_reg  <= '0;
            end
        end
    end

    // Best candidate and earliest future arrival
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            if (is_ready && better)
            begin
                best_idx_reg   <= idx_reg;
                best_pri_reg   <= rd_pri_reg;
                best_stamp_reg <= eff_stamp;
                best_arr_reg   <= rd_arr_reg;
                best_dur_reg   <= rd_dur_reg;
            end
            if (is_later && (!min_valid_reg || rd_arr_reg < min_arr_reg))
                min_arr_reg <= rd_arr_reg;
        end
    end

    // Result registers, loaded on dispatch
    always_ff @(posedge clk)
    begin
        if (cmd.commit && best_valid_reg)
        begin
            id_reg      <= JOBID_W'(IDX_W'(best_idx_reg) + (IDX_W+1)'(1));
            start_reg   <= time_reg;
            fin_reg     <= fin_next;
            tat_reg     <= fin_next - TIME_W'(best_arr_reg);
            resp_reg    <= resp_next;
            ovf_out_reg <= ovf_reg;
            eor_reg     <= (done_reg + CNT_W'(1)) == count_reg;
        end
    end

    assign status.scan_last  = (idx_reg == '0);
    assign status.best_valid = best_valid_reg;
    assign status.min_valid  = min_valid_reg;
    assign status.eor        = eor_reg;

    assign job_id      = id_reg;
    assign start_time  = start_reg;
    assign finish_time = fin_reg;
    assign turnaround  = tat_reg;
    assign waiting     = resp_reg;
    assign response    = resp_reg;
    assign overflowed  = ovf_out_reg;
    assign end_of_run  = eor_reg;

endmodule

/* rtl/nps_ctrl.sv */
// Controller state machine sequencing load, sweep, dispatch and output.
module nps_ctrl
    import nps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        last,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    output nps_cmd_t    cmd,
    input  nps_status_t status
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       in_fire;
    logic       out_fire;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid && !out_stall;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    if (last)
                    begin
                        cmd.begin_run = 1'b1;
                        state_next    = S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                cmd.scan_init = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.commit = 1'b1;
                if (status.best_valid)
                    state_next = S_OUT;
                else if (status.min_valid)
                    state_next = S_PREP;
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (out_fire)
                begin
                    if (status.eor)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_PREP;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/nps_checker.sv */
// Port-level checks on the scheduler, bound to the top level.
module nps_checker
    import nps_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [JOBID_W-1:0] job_id,
    input logic [TIME_W-1:0]  start_time,
    input logic [TIME_W-1:0]  finish_time,
    input logic               end_of_run
);

    // A stalled result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(job_id) && $stable(finish_time))
        else $error("result changed while stalled");

    // No job is taken while a result waits
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result pending");

    // After the final result is taken the block is open for a new batch
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && end_of_run |=> !in_stall && !out_valid)
        else $error("block not idle after end of run");

    // A job never finishes before it starts
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> start_time <= finish_time)
        else $error("finish before start");

endmodule

bind nonpreemptive_priority_scheduler nps_checker u_nps_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .job_id      (job_id),
    .start_time  (start_time),
    .finish_time (finish_time),
    .end_of_run  (end_of_run)
);

/* sim/nonpreemptive_priority_scheduler_tb.sv */
// Self-checking testbench for the non-preemptive priority scheduler.
module nonpreemptive_priority_scheduler_tb;
    import nps_pkg::*;

    typedef struct {
        logic [ARR_W-1:0] arr;
        logic [DUR_W-1:0] dur;
        logic [PRI_W-1:0] pri;
        logic             lst;
    } job_t;

    typedef struct {
        logic [JOBID_W-1:0] id;
        logic [TIME_W-1:0]  st;
        logic [TIME_W-1:0]  fin;
        logic [TIME_W-1:0]  tat;
        logic [TIME_W-1:0]  wt;
        logic [TIME_W-1:0]  rsp;
        logic               ovf;
        logic               eor;
    } sched_res_t;

    // directed row: job plus an optional hand-typed result for single-job batches
    typedef struct {
        job_t       job;
        logic       typed;
        sched_res_t res;
    } vec_t;

    localparam int LIMIT = 3000000;

    logic               clk, rst_n;
    logic               in_valid, in_stall;
    logic [ARR_W-1:0]   arrival;
    logic [DUR_W-1:0]   duration;
    logic [PRI_W-1:0]   priority_req;
    logic               last;
    logic               out_valid, out_stall;
    logic [JOBID_W-1:0] job_id;
    logic [TIME_W-1:0]  start_time, finish_time, turnaround, waiting, response;
    logic               overflowed, end_of_run;

    nonpreemptive_priority_scheduler dut (.*);

    // predictor state
    logic [ARR_W-1:0]  batch_arr [MAX_JOBS];
    logic [DUR_W-1:0]  batch_dur [MAX_JOBS];
    logic [PRI_W-1:0]  batch_pri [MAX_JOBS];
    int                batch_len;
    bit                batch_ovf;
    sched_res_t        pending_results[$];
    sched_res_t        typed_results[$];
    int                fail_count;
    int                sent_count;
    bit                quiet;      // no idling in the final part
    bit                hold_out;   // long receiver hold-off

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // compute completion order for the stored batch
    task automatic schedule_batch();
        logic [1:0]  jst [MAX_JOBS];
        logic [31:0] stamp [MAX_JOBS];
        logic [31:0] now, fin, nxt;
        int done, best;
        bit found;
        sched_res_t r;
        for (int i = 0; i < MAX_JOBS; i++) jst[i] = ST_PENDING;
        now = 0;
        done = 0;
        while (done < batch_len)
        begin
            for (int i = 0; i < batch_len; i++)
                if (jst[i] == ST_PENDING && batch_arr[i] <= now)
                begin
                    jst[i] = ST_READY;
                    stamp[i] = now;
                end
            best = -1;
            for (int j = batch_len - 1; j >= 0; j--)
                if (jst[j] == ST_READY && (best < 0 || batch_pri[j] < batch_pri[best] ||
                    (batch_pri[j] == batch_pri[best] && stamp[j] < stamp[best])))
                    best = j;
            if (best >= 0)
            begin
                fin = now + batch_dur[best];
                r.id  = best + 1;
                r.st  = now;
                r.fin = fin;
                r.tat = fin - batch_arr[best];
                r.wt  = fin - batch_arr[best] - batch_dur[best];
                r.rsp = now - batch_arr[best];
                r.ovf = batch_ovf;
                done++;
                r.eor = (done == batch_len);
                pending_results.push_back(r);
                jst[best] = ST_DONE;
                now = fin;
            end
            else
            begin
                found = 0;
                nxt = 0;
                for (int i = 0; i < batch_len; i++)
                    if (jst[i] == ST_PENDING && (!found || batch_arr[i] < nxt))
                    begin
                        nxt = batch_arr[i];
                        found = 1;
                    end
                now = nxt;
            end
        end
        batch_len = 0;
        batch_ovf = 0;
    endtask

    // absorb one accepted job into the predictor
    task automatic accept_job(job_t j);
        if (batch_len < MAX_JOBS)
        begin
            batch_arr[batch_len] = j.arr;
            batch_dur[batch_len] = j.dur;
            batch_pri[batch_len] = j.pri;
            batch_len++;
        end
        else
            batch_ovf = 1;
        if (j.lst) schedule_batch();
    endtask

    // offer one transaction, with random gaps before it
    task automatic send_job(job_t j);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid     <= 1;
        arrival      <= j.arr;
        duration     <= j.dur;
        priority_req <= j.pri;
        last         <= j.lst;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        accept_job(j);
        sent_count++;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    function automatic job_t rand_job(bit lst, int arr_hi, int dur_hi);
        job_t j;
        int r;
        r = $urandom_range(0, 9);
        j.arr = (r == 0) ? 16'hFFFF : $urandom_range(0, arr_hi);
        j.dur = (r == 1) ? 16'hFFFF : (r == 2) ? 16'd0 : $urandom_range(0, dur_hi);
        j.pri = (r == 3) ? 8'hFF : $urandom_range(0, (r < 6) ? 3 : 255);
        j.lst = lst;
        return j;
    endfunction

    function automatic sched_res_t one_res(int fin, int ovf);
        sched_res_t r;
        r = '{id: 1, st: 0, fin: fin, tat: fin, wt: 0, rsp: 0, ovf: ovf, eor: 1};
        return r;
    endfunction

    // stimulus
    initial
    begin
        vec_t dir [$];
        job_t j;
        int n;
        rst_n = 0;
        in_valid = 0; arrival = 0; duration = 0; priority_req = 0; last = 0;
        fail_count = 0; sent_count = 0; quiet = 0; hold_out = 0;
        batch_len = 0; batch_ovf = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // single jobs at the field extremes, with results typed in
        dir.push_back('{'{16'h0000, 16'h0000, 8'h00, 1}, 1, one_res(0, 0)});
        dir.push_back('{'{16'h0000, 16'hFFFF, 8'hFF, 1}, 1, one_res(65535, 0)});
        dir.push_back('{'{16'hFFFF, 16'hFFFF, 8'h00, 1}, 1,
            '{1, 65535, 131070, 65535, 0, 0, 0, 1}});
        // ties: same priority, same arrival -> higher id first
        dir.push_back('{'{16'd5, 16'd3, 8'd2, 0}, 0, one_res(0, 0)});
        dir.push_back('{'{16'd5, 16'd3, 8'd2, 0}, 0, one_res(0, 0)});
        dir.push_back('{'{16'd5, 16'd0, 8'd2, 1}, 0, one_res(0, 0)});
        // earlier ready stamp wins over later arrival at equal priority
        dir.push_back('{'{16'd0, 16'd10, 8'd7, 0}, 0, one_res(0, 0)});
        dir.push_back('{'{16'd1, 16'd4, 8'd3, 0}, 0, one_res(0, 0)});
        dir.push_back('{'{16'd12, 16'd2, 8'd3, 0}, 0, one_res(0, 0)});
        dir.push_back('{'{16'd2, 16'd2, 8'd9, 0}, 0, one_res(0, 0)});
        dir.push_back('{'{16'd900, 16'd1, 8'd0, 1}, 0, one_res(0, 0)});
        foreach (dir[i])
        begin
            if (dir[i].typed) typed_results.push_back(dir[i].res);
            send_job(dir[i].job);
            if (dir[i].job.lst) drain();
        end
        typed_results.delete();

        // overflow: 19 jobs, last three dropped
        for (int i = 0; i < MAX_JOBS + 3; i++)
        begin
            j = rand_job(i == MAX_JOBS + 2, 300, 40);
            send_job(j);
        end
        drain();

        // long receiver hold-off while the sender keeps offering
        hold_out = 1;
        for (int i = 0; i < 6; i++) send_job(rand_job(i == 5, 100, 20));
        for (int i = 0; i < 3; i++) send_job(rand_job(i == 2, 100, 20));
        hold_out = 0;
        drain();

        // random batches: mostly small, a few of 14 to 18 jobs
        while (sent_count < 420)
        begin
            if (sent_count > 360) quiet = 1;
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                send_job(rand_job(i == n - 1, ($urandom_range(0, 1)) ? 50 : 65535, 60));
            if ($urandom_range(0, 4) == 0) drain();
        end
        drain();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("** nonpreemptive_priority_scheduler: PASSED **");
        else
            $display("** nonpreemptive_priority_scheduler: FAILED **");
        $finish;
    end

    // receiver stall: random bursts, plus a counted long hold-off
    initial
    begin
        int hold;
        out_stall = 0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold_out && hold < 400)
            begin
                out_stall <= 1;
                hold++;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1;
                repeat ($urandom_range(1, 11) - 1) @(posedge clk);
            end
            else
                out_stall <= 0;
        end
    end

    // check each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        sched_res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with no expectation: job_id %0d", job_id);
                fail_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (typed_results.size() != 0)
                begin
                    if (typed_results[0] != e)
                    begin
                        $error("predictor disagrees with typed result");
                        fail_count++;
                    end
                    void'(typed_results.pop_front());
                end
                if (job_id !== e.id)
                begin
                    $error("job_id exp %0d got %0d", e.id, job_id); fail_count++;
                end
                if (start_time !== e.st)
                begin
                    $error("start_time exp %0d got %0d", e.st, start_time); fail_count++;
                end
                if (finish_time !== e.fin)
                begin
                    $error("finish_time exp %0d got %0d", e.fin, finish_time); fail_count++;
                end
                if (turnaround !== e.tat)
                begin
                    $error("turnaround exp %0d got %0d", e.tat, turnaround); fail_count++;
                end
                if (waiting !== e.wt)
                begin
                    $error("waiting exp %0d got %0d", e.wt, waiting); fail_count++;
                end
                if (response !== e.rsp)
                begin
                    $error("response exp %0d got %0d", e.rsp, response); fail_count++;
                end
                if (overflowed !== e.ovf)
                begin
                    $error("overflowed exp %0d got %0d", e.ovf, overflowed); fail_count++;
                end
                if (end_of_run !== e.eor)
                begin
                    $error("end_of_run exp %0d got %0d", e.eor, end_of_run); fail_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        int cyc;
        cyc = 0;
        while (cyc < LIMIT)
        begin
            @(posedge clk);
            cyc++;
        end
        $display("** nonpreemptive_priority_scheduler: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
rtl/nps_pkg.sv
rtl/nps_datapath.sv
rtl/nps_ctrl.sv
rtl/nonpreemptive_priority_scheduler.sv
rtl/nps_checker.sv
sim/nonpreemptive_priority_scheduler_tb.sv
